// File: rtl/sop_pkg.sv
// ----------------------------------------------------------------------------
// sop_pkg: shared types and constants of the sphere overlap push-out block
// Request and result payloads, pipeline sideband records and latency figures.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sop_pkg;

    // fixed point constants
    localparam logic [16:0] SHARE_ONE = 17'd65536;

    // stage counts of the iterative units
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 32;

    // accepted request to result strobe, in cycles
    localparam int SOP_LATENCY = 4 + SQRT_STAGES + 2 + DIV_STAGES + 2;

    // one request
    typedef struct packed {
        logic [31:0] center_a_x;
        logic [31:0] center_a_y;
        logic [31:0] center_a_z;
        logic [31:0] center_b_x;
        logic [31:0] center_b_y;
        logic [31:0] center_b_z;
        logic [30:0] radius_a;
        logic [30:0] radius_b;
        logic        trigger_only;
        logic [16:0] push_share;
    } sop_req_t;

    // one result
    typedef struct packed {
        logic        hit;
        logic [31:0] move_a_x;
        logic [31:0] move_a_y;
        logic [31:0] move_a_z;
        logic [31:0] move_b_x;
        logic [31:0] move_b_y;
        logic [31:0] move_b_z;
    } sop_res_t;

    // data carried alongside the square root pipeline
    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [31:0]      range;
        logic             hit;
        logic             trig;
        logic [16:0]      share;
    } sop_sqrt_side_t;

    // data carried alongside the divider pipeline
    typedef struct packed {
        logic [2:0]  neg;
        logic        hit;
        logic        push;
        logic [16:0] share;
    } sop_div_side_t;

endpackage

`default_nettype wire

// File: rtl/sop_isqrt.sv
// ----------------------------------------------------------------------------
// sop_isqrt: pipelined integer square root
// Floor square root of a 64-bit value, one result bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sop_isqrt
    import sop_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic [63:0]    radicand,
    input  wire sop_sqrt_side_t in_side,
    output logic                out_valid,
    output logic [31:0]         root,
    output sop_sqrt_side_t      out_side
);

    logic           valid_reg [0:SQRT_STAGES];
    logic [63:0]    rad_reg   [0:SQRT_STAGES];
    logic [32:0]    rem_reg   [0:SQRT_STAGES];
    logic [31:0]    root_reg  [0:SQRT_STAGES];
    sop_sqrt_side_t side_reg  [0:SQRT_STAGES];

    // stage zero is the incoming request
    assign valid_reg[0] = in_valid;
    assign rad_reg[0]   = radicand;
    assign rem_reg[0]   = '0;
    assign root_reg[0]  = '0;
    assign side_reg[0]  = in_side;

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [34:0] rem_sh;
        logic [34:0] trial;
        logic [34:0] diff;
        logic [32:0] rem_next;
        logic [31:0] root_next;

        // one root bit: bring down two radicand bits and try the subtraction
        always_comb
        begin
            rem_sh = {rem_reg[k], rad_reg[k][63:62]};
            trial  = {1'b0, root_reg[k], 2'b01};
            diff   = rem_sh - trial;
            if (rem_sh >= trial)
            begin
                rem_next  = diff[32:0];
                root_next = {root_reg[k][30:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[32:0];
                root_next = {root_reg[k][30:0], 1'b0};
            end
        end

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else
                valid_reg[k+1] <= valid_reg[k];
        end

        // stage data
        always_ff @(posedge clk)
        begin
            rad_reg[k+1]  <= {rad_reg[k][61:0], 2'b00};
            rem_reg[k+1]  <= rem_next;
            root_reg[k+1] <= root_next;
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = valid_reg[SQRT_STAGES];
    assign root      = root_reg[SQRT_STAGES];
    assign out_side  = side_reg[SQRT_STAGES];

endmodule

`default_nettype wire

// File: rtl/sop_div3.sv
// ----------------------------------------------------------------------------
// sop_div3: pipelined three-lane divider
// Divides three 64-bit numerators by one 32-bit divisor, one quotient bit
// per register stage; each quotient is known to fit in 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sop_div3
    import sop_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [2:0][63:0] num,
    input  wire logic [31:0]     den,
    input  wire sop_div_side_t   in_side,
    output logic                 out_valid,
    output logic [2:0][31:0]     quot,
    output sop_div_side_t        out_side
);

    logic             valid_reg [0:DIV_STAGES];
    logic [2:0][31:0] rem_reg   [0:DIV_STAGES];
    logic [2:0][31:0] low_reg   [0:DIV_STAGES];
    logic [31:0]      den_reg   [0:DIV_STAGES];
    sop_div_side_t    side_reg  [0:DIV_STAGES];

    // stage zero: upper half is the starting remainder
    assign valid_reg[0] = in_valid;
    assign den_reg[0]   = den;
    assign side_reg[0]  = in_side;
    for (genvar j = 0; j < 3; j++) begin : g_init
        assign rem_reg[0][j] = num[j][63:32];
        assign low_reg[0][j] = num[j][31:0];
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [2:0][31:0] rem_next;
        logic [2:0][31:0] low_next;

        // one quotient bit per lane, shifted in where the numerator leaves
        always_comb
        begin
            logic [32:0] rem_sh;
            logic [32:0] diff;
            for (int j = 0; j < 3; j++)
            begin
                rem_sh = {rem_reg[k][j], low_reg[k][j][31]};
                diff   = rem_sh - {1'b0, den_reg[k]};
                if (rem_sh >= {1'b0, den_reg[k]})
                begin
                    rem_next[j] = diff[31:0];
                    low_next[j] = {low_reg[k][j][30:0], 1'b1};
                end
                else
                begin
                    rem_next[j] = rem_sh[31:0];
                    low_next[j] = {low_reg[k][j][30:0], 1'b0};
                end
            end
        end

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else
                valid_reg[k+1] <= valid_reg[k];
        end

        // stage data
        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= rem_next;
            low_reg[k+1]  <= low_next;
            den_reg[k+1]  <= den_reg[k];
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = valid_reg[DIV_STAGES];
    assign quot      = low_reg[DIV_STAGES];
    assign out_side  = side_reg[DIV_STAGES];

endmodule

`default_nettype wire

// File: rtl/sphere_overlap_pushout.sv
// ----------------------------------------------------------------------------
// sphere_overlap_pushout: sphere pair overlap test and push-out response
// Fully pipelined; one sphere pair per cycle, one result per pair.
// ----------------------------------------------------------------------------
// Usage:
//   A request (two centres, two radii, trigger_only, push_share, all Q16.16
//   or Q1.16) is taken at a rising edge with start high and busy low. busy
//   is held low: the pipeline takes a new request every cycle.
//   Each result appears on res for exactly one cycle with done high, in
//   request order.
//   The latency is set by the square root (32 stages, one root bit each) and
//   the divider (32 stages, one quotient bit each), plus eight stages for
//   differences, squares, sum, compare, depth, products, share and
//   saturation.
//   The receiver cannot stall; results are not held.
//   Reset clears all valid bits; no result is produced for requests in
//   flight at reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sphere_overlap_pushout
    import sop_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire sop_req_t req,
    output logic          done,
    output sop_res_t      res
);

    // saturate a magnitude with a sign to 32 bits signed
    function automatic logic [31:0] sat32(input logic negative, input logic [32:0] mag);
        logic [32:0] negd;
        negd = 33'd0 - mag;
        if (negative)
            sat32 = (mag >= 33'h080000000) ? 32'h80000000 : negd[31:0];
        else
            sat32 = (mag > 33'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
    endfunction

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // stage 1: differences, magnitudes, radius sum, share clamp
    logic             s1_valid_reg;
    logic [2:0][32:0] s1_mag_reg;
    logic [2:0]       s1_neg_reg;
    logic [31:0]      s1_range_reg;
    logic             s1_trig_reg;
    logic [16:0]      s1_share_reg;

    logic [2:0][32:0] s1_mag_next;
    logic [2:0]       s1_neg_next;
    always_comb
    begin
        logic [2:0][31:0] ca;
        logic [2:0][31:0] cb;
        logic [32:0]      d;
        ca = {req.center_a_z, req.center_a_y, req.center_a_x};
        cb = {req.center_b_z, req.center_b_y, req.center_b_x};
        for (int i = 0; i < 3; i++)
        begin
            d              = {cb[i][31], cb[i]} - {ca[i][31], ca[i]};
            s1_neg_next[i] = d[32];
            s1_mag_next[i] = d[32] ? (33'd0 - d) : d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        s1_mag_reg   <= s1_mag_next;
        s1_neg_reg   <= s1_neg_next;
        s1_range_reg <= {1'b0, req.radius_a} + {1'b0, req.radius_b};
        s1_trig_reg  <= req.trigger_only;
        s1_share_reg <= (req.push_share > SHARE_ONE) ? SHARE_ONE : req.push_share;
    end

    // stage 2: squares; a magnitude of 2^32 can never overlap
    logic             s2_valid_reg;
    logic [2:0][63:0] s2_sq_reg;
    logic [63:0]      s2_range2_reg;
    logic             s2_big_reg;
    sop_sqrt_side_t   s2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_sq_reg[i]       <= {32'd0, s1_mag_reg[i][31:0]} * {32'd0, s1_mag_reg[i][31:0]};
            s2_side_reg.mag[i] <= s1_mag_reg[i][31:0];
        end
        s2_range2_reg     <= {32'd0, s1_range_reg} * {32'd0, s1_range_reg};
        s2_big_reg        <= s1_mag_reg[0][32] | s1_mag_reg[1][32] | s1_mag_reg[2][32];
        s2_side_reg.neg   <= s1_neg_reg;
        s2_side_reg.range <= s1_range_reg;
        s2_side_reg.hit   <= 1'b0;
        s2_side_reg.trig  <= s1_trig_reg;
        s2_side_reg.share <= s1_share_reg;
    end

    // stage 3: squared distance
    logic           s3_valid_reg;
    logic [65:0]    s3_l2_reg;
    logic [63:0]    s3_range2_reg;
    logic           s3_big_reg;
    sop_sqrt_side_t s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_l2_reg     <= {2'b00, s2_sq_reg[0]} + {2'b00, s2_sq_reg[1]}
                       + {2'b00, s2_sq_reg[2]};
        s3_range2_reg <= s2_range2_reg;
        s3_big_reg    <= s2_big_reg;
        s3_side_reg   <= s2_side_reg;
    end

    // stage 4: overlap compare
    logic           s4_valid_reg;
    logic [63:0]    s4_l2_reg;
    sop_sqrt_side_t s4_side_reg;
    sop_sqrt_side_t s4_side_next;

    always_comb
    begin
        s4_side_next     = s3_side_reg;
        s4_side_next.hit = !s3_big_reg && (s3_l2_reg < {2'b00, s3_range2_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_l2_reg   <= s3_l2_reg[63:0];
        s4_side_reg <= s4_side_next;
    end

    // centre distance
    logic           sq_valid;
    logic [31:0]    sq_root;
    sop_sqrt_side_t sq_side;

    sop_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .radicand  (s4_l2_reg),
        .in_side   (s4_side_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    // stage 5: penetration depth
    logic             s5_valid_reg;
    logic [31:0]      s5_depth_reg;
    logic [31:0]      s5_dist_reg;
    logic [2:0][31:0] s5_mag_reg;
    sop_div_side_t    s5_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else
            s5_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        s5_depth_reg      <= sq_side.range - sq_root;
        s5_dist_reg       <= sq_root;
        s5_mag_reg        <= sq_side.mag;
        s5_side_reg.neg   <= sq_side.neg;
        s5_side_reg.hit   <= sq_side.hit;
        s5_side_reg.push  <= sq_side.hit && !sq_side.trig && (sq_root != 32'd0);
        s5_side_reg.share <= sq_side.share;
    end

    // stage 6: axis magnitude times depth
    logic             s6_valid_reg;
    logic [2:0][63:0] s6_prod_reg;
    logic [31:0]      s6_dist_reg;
    sop_div_side_t    s6_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            s6_prod_reg[i] <= {32'd0, s5_mag_reg[i]} * {32'd0, s5_depth_reg};
        s6_dist_reg <= s5_dist_reg;
        s6_side_reg <= s5_side_reg;
    end

    // push vector per axis
    logic             dv_valid;
    logic [2:0][31:0] dv_quot;
    sop_div_side_t    dv_side;

    sop_div3 u_div3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s6_valid_reg),
        .num       (s6_prod_reg),
        .den       (s6_dist_reg),
        .in_side   (s6_side_reg),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .out_side  (dv_side)
    );

    // stage 7: split by push share
    logic             s7_valid_reg;
    logic [2:0][32:0] s7_am_reg;
    logic [2:0][32:0] s7_bm_reg;
    sop_div_side_t    s7_side_reg;

    logic [16:0] rest_share;
    assign rest_share = SHARE_ONE - dv_side.share;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_valid_reg <= 1'b0;
        else
            s7_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        logic [48:0] pa;
        logic [48:0] pb;
        for (int i = 0; i < 3; i++)
        begin
            pa = {17'd0, dv_quot[i]} * {32'd0, rest_share};
            pb = {17'd0, dv_quot[i]} * {32'd0, dv_side.share};
            s7_am_reg[i] <= pa[48:16];
            s7_bm_reg[i] <= pb[48:16];
        end
        s7_side_reg <= dv_side;
    end

    // stage 8: sign, saturation and result register
    logic     done_reg;
    sop_res_t res_reg;

    logic [2:0][31:0] ma;
    logic [2:0][31:0] mb;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (s7_side_reg.push)
            begin
                ma[i] = sat32(!s7_side_reg.neg[i] && (s7_am_reg[i] != 33'd0), s7_am_reg[i]);
                mb[i] = sat32(s7_side_reg.neg[i] && (s7_bm_reg[i] != 33'd0), s7_bm_reg[i]);
            end
            else
            begin
                ma[i] = '0;
                mb[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s7_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        res_reg.hit      <= s7_side_reg.hit;
        res_reg.move_a_x <= ma[0];
        res_reg.move_a_y <= ma[1];
        res_reg.move_a_z <= ma[2];
        res_reg.move_b_x <= mb[0];
        res_reg.move_b_y <= mb[1];
        res_reg.move_b_z <= mb[2];
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

// File: rtl/sop_checker.sv
// ----------------------------------------------------------------------------
// sop_checker: port-level checks for sphere_overlap_pushout
// Latency, never-busy and result consistency, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sop_checker
    import sop_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire sop_req_t req,
    input wire logic     done,
    input wire sop_res_t res
);

    // the pipeline never pushes back
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // every request gives a result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##SOP_LATENCY done)
        else $error("result missing at expected latency");

    // no displacement without an overlap
    a_move_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !res.hit) |-> (res.move_a_x == 32'd0 && res.move_a_y == 32'd0
            && res.move_a_z == 32'd0 && res.move_b_x == 32'd0
            && res.move_b_y == 32'd0 && res.move_b_z == 32'd0))
        else $error("displacement without hit");

    // the two spheres are pushed in opposite directions along x
    a_opposite_x: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.move_a_x != 32'd0 && res.move_b_x != 32'd0)
            |-> (res.move_a_x[31] != res.move_b_x[31]))
        else $error("push directions not opposite");

endmodule

bind sphere_overlap_pushout sop_checker u_sop_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .res   (res)
);

`default_nettype wire

// File: test/sop_checker.sv
// ----------------------------------------------------------------------------
// sop_result_checker: result checker for the sphere overlap push-out block
// Watches accepted requests, predicts each push-out result in order and
// compares every strobed result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sop_result_checker
    import sop_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     busy,
    input  wire sop_req_t req,
    input  wire logic     done,
    input  wire sop_res_t res,
    output int            fail_count,
    output int            pending,
    output int            hits_seen,
    output int            pushes_seen,
    output int            results_seen
);

    sop_res_t pushout_q[$];

    // integer square root, floor
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 64'd0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // signed saturation of a magnitude
    function automatic logic [31:0] clamp_move(input logic negative, input logic [63:0] m);
        if (negative)
            return (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-m);
        return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    endfunction

    function automatic sop_res_t predict_pushout(input sop_req_t r);
        sop_res_t     o;
        logic [2:0][31:0] ca, cb;
        logic signed [33:0] d[3];
        logic [63:0]  mag[3];
        logic [63:0]  l2, sq, range, range2, share, root_dist, depth, p, bm, am;
        logic [127:0] wide;
        o = '0;
        ca = {r.center_a_z, r.center_a_y, r.center_a_x};
        cb = {r.center_b_z, r.center_b_y, r.center_b_x};
        range = 64'(r.radius_a) + 64'(r.radius_b);
        range2 = range * range;
        share = (r.push_share > SHARE_ONE) ? 64'(SHARE_ONE) : 64'(r.push_share);
        l2 = 64'd0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = 34'(signed'(cb[i])) - 34'(signed'(ca[i]));
            mag[i] = d[i][33] ? 64'(-d[i]) : 64'(d[i]);
            sq = mag[i] * mag[i];
            if (l2 > 64'hFFFF_FFFF_FFFF_FFFF - sq)
                l2 = 64'hFFFF_FFFF_FFFF_FFFF;
            else
                l2 = l2 + sq;
        end
        if (!(l2 < range2))
            return o;
        o.hit = 1'b1;
        if (r.trigger_only)
            return o;
        root_dist = root_floor(l2);
        depth = range - root_dist;
        // coincident centres (distance rounds to zero) push nothing
        if (root_dist == 64'd0)
            return o;
        for (int i = 0; i < 3; i++)
        begin
            wide = 128'(mag[i]) * 128'(depth);
            p = 64'(wide / 128'(root_dist));
            bm = (p * share) >> 16;
            am = (p * (64'(SHARE_ONE) - share)) >> 16;
            case (i)
                0: begin o.move_a_x = clamp_move(!d[i][33] && am != 0, am);
                         o.move_b_x = clamp_move(d[i][33] && bm != 0, bm); end
                1: begin o.move_a_y = clamp_move(!d[i][33] && am != 0, am);
                         o.move_b_y = clamp_move(d[i][33] && bm != 0, bm); end
                default: begin o.move_a_z = clamp_move(!d[i][33] && am != 0, am);
                         o.move_b_z = clamp_move(d[i][33] && bm != 0, bm); end
            endcase
        end
        return o;
    endfunction

    task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a)
        begin
            $error("%s mismatch: expected %h, actual %h", name, e, a);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
        hits_seen = 0;
        pushes_seen = 0;
        results_seen = 0;
    end

    // capture requests and compare results
    always @(posedge clk)
    begin
        sop_res_t e;
        if (rst_n)
        begin
            if (done)
            begin
                results_seen++;
                if (pushout_q.size() == 0)
                begin
                    $error("result with no request waiting");
                    fail_count++;
                end
                else
                begin
                    e = pushout_q.pop_front();
                    check_field("hit", 32'(e.hit), 32'(res.hit));
                    check_field("move_a_x", e.move_a_x, res.move_a_x);
                    check_field("move_a_y", e.move_a_y, res.move_a_y);
                    check_field("move_a_z", e.move_a_z, res.move_a_z);
                    check_field("move_b_x", e.move_b_x, res.move_b_x);
                    check_field("move_b_y", e.move_b_y, res.move_b_y);
                    check_field("move_b_z", e.move_b_z, res.move_b_z);
                    if (e.hit)
                        hits_seen++;
                    if (e.move_b_x | e.move_b_y | e.move_b_z | e.move_a_x
                        | e.move_a_y | e.move_a_z)
                        pushes_seen++;
                end
            end
            if (start && !busy)
                pushout_q.push_back(predict_pushout(req));
            pending = pushout_q.size();
        end
    end

endmodule

// File: test/tb_sphere_overlap_pushout.sv
// ----------------------------------------------------------------------------
// tb_sphere_overlap_pushout: testbench top for the sphere push-out block
// Drives directed and random sphere pairs with varying sender idling and
// gives the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sphere_overlap_pushout
    import sop_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 20 * SOP_LATENCY + 2000;
    localparam int RANDOM_REQUESTS = 1850;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    sop_req_t req;
    logic     done;
    sop_res_t res;
    int       fail_count, pending, hits_seen, pushes_seen, results_seen;
    int       idle_pct;
    int       quiet_cycles;
    int       requests_sent;

    sphere_overlap_pushout dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .done(done), .res(res)
    );

    sop_result_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .res(res), .fail_count(fail_count), .pending(pending),
        .hits_seen(hits_seen), .pushes_seen(pushes_seen),
        .results_seen(results_seen)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    // issue one request, with random sender idling first
    task automatic send_request(input sop_req_t r);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic send_random;
        sop_req_t r;
        int mode;
        mode = $urandom_range(0, 9);
        mode = (mode < 6) ? 1 : (mode < 8) ? 2 : (mode < 9) ? 0 : 3;
        r.center_a_x = rand_coord(mode);
        r.center_a_y = rand_coord(mode);
        r.center_a_z = rand_coord(mode);
        // B near A in most cases, so overlaps are common
        if ($urandom_range(0, 3) != 0)
        begin
            r.center_b_x = r.center_a_x + rand_coord(2) * $urandom_range(1, 3000);
            r.center_b_y = r.center_a_y + rand_coord(2) * $urandom_range(1, 3000);
            r.center_b_z = r.center_a_z + rand_coord(2) * $urandom_range(1, 3000);
        end
        else
        begin
            r.center_b_x = rand_coord(mode);
            r.center_b_y = rand_coord(mode);
            r.center_b_z = rand_coord(mode);
        end
        if ($urandom_range(0, 19) == 0)
            {r.center_b_x, r.center_b_y, r.center_b_z} =
                {r.center_a_x, r.center_a_y, r.center_a_z};
        case ($urandom_range(0, 3))
            0: begin r.radius_a = 31'($urandom()); r.radius_b = 31'($urandom()); end
            1: begin r.radius_a = 31'($urandom_range(0, 30 << 16));
                     r.radius_b = 31'($urandom_range(0, 30 << 16)); end
            2: begin r.radius_a = 31'($urandom_range(0, 30000000));
                     r.radius_b = 31'($urandom_range(0, 3000000)); end
            default: begin r.radius_a = 31'h7FFF_FFFF; r.radius_b = 31'($urandom()); end
        endcase
        r.trigger_only = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 4))
            0: r.push_share = 17'($urandom());
            1: r.push_share = SHARE_ONE;
            2: r.push_share = 17'd0;
            default: r.push_share = 17'($urandom_range(0, 65536));
        endcase
        send_request(r);
    endtask

    task automatic drain_results;
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sop_req_t r;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        idle_pct = 0;
        quiet_cycles = 0;
        requests_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, trigger only, coincident centres, share clamp
        r = '0;
        send_request(r);
        r.radius_a = 31'h7FFF_FFFF;
        r.radius_b = 31'h7FFF_FFFF;
        send_request(r);
        r.push_share = 17'h1FFFF;
        r.center_b_x = 32'h0001_0000;
        send_request(r);
        r.trigger_only = 1'b1;
        send_request(r);
        r.trigger_only = 1'b0;
        r.push_share = 17'd0;
        r.center_a_x = 32'h8000_0000;
        r.center_a_y = 32'h8000_0000;
        r.center_a_z = 32'h8000_0000;
        r.center_b_x = 32'h7FFF_FFFF;
        r.center_b_y = 32'h7FFF_FFFF;
        r.center_b_z = 32'h7FFF_FFFF;
        send_request(r);
        r.center_b_x = 32'h8000_0001;
        r.push_share = 17'd32768;
        send_request(r);
        r.center_a_x = 32'h7FFF_FFFF;
        r.center_a_y = 32'hFFFF_0000;
        r.center_a_z = 32'h0000_FFFF;
        r.center_b_x = 32'h7FFF_0000;
        r.center_b_y = 32'h0001_0000;
        r.center_b_z = 32'hFFFF_FFFF;
        r.radius_a = 31'h0002_0000;
        r.radius_b = 31'h0001_8000;
        r.push_share = SHARE_ONE;
        send_request(r);
        r.push_share = 17'd1;
        send_request(r);
        r.radius_a = 31'd0;
        r.radius_b = 31'd0;
        send_request(r);
        r.radius_a = 31'h5555_5555;
        r.radius_b = 31'h2AAA_AAAA;
        r.push_share = 17'h0AAAA;
        send_request(r);

        // pause until every directed result is back
        drain_results();

        // random requests over the idling phases
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 57 : (ph == 3) ? 24 : 0;
            for (int n = 0; n < RANDOM_REQUESTS / 4; n++)
                send_random();
        end

        drain_results();
        repeat (SOP_LATENCY + 10) @(posedge clk);

        $display("Run covered %0d requests, %0d results, %0d hits, %0d with push-out.",
                 requests_sent, results_seen, hits_seen, pushes_seen);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
